// File: hdl/ocsv_pkg.sv
// Package for the odd cosine series velocity block: sizes, constants and
// the CORDIC arctangent table. No dependencies.
`timescale 1ns / 1ps
package ocsv_pkg;
  localparam int MAX_TERMS    = 32;
  localparam int CORDIC_STEPS = 24;
  localparam int IDX_W        = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);

  localparam logic [63:0] INV2PI     = 64'h28BE60DB9391054A;
  localparam logic signed [33:0] TWO_PI_Q29 = 34'sd3373259426;
  localparam logic signed [47:0] CORDIC_GAIN = 48'sd652032875;
  localparam logic signed [47:0] ONE_Q30 = 48'sd1073741824;

  localparam logic [2:0] REG_BASE  = 3'd0;
  localparam logic [2:0] REG_PERT  = 3'd1;
  localparam logic [2:0] REG_WAVE  = 3'd2;
  localparam logic [2:0] REG_TERMS = 3'd3;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PHASE, ST_PHASE2, ST_ANGLE, ST_COS, ST_SCALE, ST_PROD,
    ST_TERM, ST_FINAL, ST_OUT
  } state_t;

  // x, y, z of one CORDIC stage
  typedef struct packed {
    logic signed [47:0] x;
    logic signed [47:0] y;
    logic signed [47:0] z;
  } rot_t;

  function automatic logic signed [47:0] atan_q30(input int i);
    logic signed [47:0] t;
    case (i)
      0: t = 48'sd843314857;  1: t = 48'sd497837829;
      2: t = 48'sd263043837;  3: t = 48'sd133525159;
      4: t = 48'sd67021687;   5: t = 48'sd33543516;
      6: t = 48'sd16775851;   7: t = 48'sd8388437;
      8: t = 48'sd4194283;    9: t = 48'sd2097149;
      default: t = (i < 31) ? (48'sd1 <<< (30 - i)) : 48'sd0;
    endcase
    return t;
  endfunction
endpackage

// File: hdl/ocsv_if.sv
// Valid/ready channel interfaces for input and result items.
// Depends on nothing.
`timescale 1ns / 1ps
interface ocsv_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [4:0]  coef_index;
  logic signed [31:0] coef_value;
  logic signed [31:0] latitude;
  logic signed [31:0] longitude;
  modport source (output valid, cmd, coef_index, coef_value, latitude, longitude,
                  input ready);
  modport sink (input valid, cmd, coef_index, coef_value, latitude, longitude,
                output ready);
endinterface

interface ocsv_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] velocity;
  logic        saturated;
  modport source (output valid, velocity, saturated, input ready);
  modport sink (input valid, velocity, saturated, output ready);
endinterface

// File: hdl/ocsv_cell.sv
// One CORDIC rotation cell: applies the micro-rotation of its step and passes on.
// Depends on ocsv_pkg.
`timescale 1ns / 1ps
module ocsv_cell
  import ocsv_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  logic [STEP_W-1:0] step,
  input  rot_t din,
  output rot_t dout
);
  logic signed [47:0] atan;

  // step is tied to a constant per cell
  assign atan = atan_q30(int'(step));

  always_ff @(posedge clk) begin
    if (en) begin
      if (din.z >= 0) begin
        dout.x <= din.x - (din.y >>> step);
        dout.y <= din.y + (din.x >>> step);
        dout.z <= din.z - atan;
      end else begin
        dout.x <= din.x + (din.y >>> step);
        dout.y <= din.y - (din.x >>> step);
        dout.z <= din.z + atan;
      end
    end
  end
endmodule

// File: hdl/ocsv_cordic.sv
// Row of CORDIC cells; a new angle may enter every cycle, the cosine leaves
// after the input register and the cells with its quadrant. Depends on ocsv_pkg, ocsv_cell.
`timescale 1ns / 1ps
module ocsv_cordic
  import ocsv_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [39:0] phase,
  output logic out_valid,
  output logic signed [47:0] cos_out
);
  rot_t chain [CORDIC_STEPS+1];
  logic [1:0] quad [CORDIC_STEPS+1];
  logic [CORDIC_STEPS:0] vld;
  logic [40:0] sh;
  logic signed [38:0] r;
  logic signed [72:0] zp;
  logic signed [47:0] c;

  // quarter-turn choice; residual to Q2.30 radians (truncate toward zero)
  always_comb begin
    sh = {1'b0, phase} + 41'(64'd1 << 37);
    r  = $signed({1'b0, sh[37:0]}) - 39'sd137438953472;
    zp = r * TWO_PI_Q29;
  end

  always_ff @(posedge clk) begin
    chain[0].x <= CORDIC_GAIN;
    chain[0].y <= '0;
    chain[0].z <= (zp < 0) ? -48'((-zp) >>> 39) : 48'(zp >>> 39);
    quad[0] <= sh[39:38];
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_row
    ocsv_cell u_cell (.clk(clk), .en(1'b1), .step(STEP_W'(i)), .din(chain[i]),
                      .dout(chain[i+1]));
    always_ff @(posedge clk) quad[i+1] <= quad[i];
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[CORDIC_STEPS-1:0], in_valid};
  end
  assign out_valid = vld[CORDIC_STEPS];

  // quadrant mapping and clip to +-1
  always_comb begin
    case (quad[CORDIC_STEPS])
      2'd0: c = chain[CORDIC_STEPS].x;
      2'd1: c = -chain[CORDIC_STEPS].y;
      2'd2: c = -chain[CORDIC_STEPS].x;
      default: c = chain[CORDIC_STEPS].y;
    endcase
    if (c > ONE_Q30) cos_out = ONE_Q30;
    else if (c < -ONE_Q30) cos_out = -ONE_Q30;
    else cos_out = c;
  end
endmodule

// File: hdl/odd_cosine_series_velocity.sv
// Top level of the odd cosine series velocity block.
// Depends on ocsv_pkg, ocsv_if, ocsv_cordic.
`timescale 1ns / 1ps
// Usage:
//  in channel: cmd 0 loads coef_value into slot coef_index (no result;
//  loads may follow back to back). cmd 1 evaluates u at (latitude,
//  longitude) and yields one item on the out channel with velocity and
//  saturated.
//  Config: cfg_we/cfg_index/cfg_data write w, epsilon, kappa, num_terms;
//  write only while idle.
//  Evaluation: two passes turn both angles into turns, then cos(phi),
//  cos(kappa*eta) and the N odd harmonics enter a row of CORDIC_STEPS cells
//  one per cycle, and the evaluation waits until the row is drained.
//  Each product goes through the shared multiplier in these steps:
//  coefficient read, partial products, rescale, accumulate.
//  One evaluation at a time; a new item is taken the cycle after the
//  result is taken. A stalled receiver holds the result and the block;
//  reset returns control, out valid and the config registers to their
//  reset values.
module odd_cosine_series_velocity
  import ocsv_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ocsv_in_if.sink   in_ch,
  ocsv_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  logic signed [31:0] base_amp, pert_scale;
  logic [7:0] wave;
  logic [5:0] terms_reg;
  logic [IDX_W:0] nterms;

  logic signed [31:0] coef_mem [MAX_TERMS];
  logic signed [31:0] coef_rd;

  state_t state, state_next;
  logic signed [31:0] lat_q, lon_q;
  logic [63:0] mag_q;
  logic [39:0] fphi, feta, fang, keta;
  logic [39:0] odd_ang, step_ang;
  logic [IDX_W:0] issue_cnt, rx_cnt, mac_cnt;
  logic issue_v, issue_go;
  logic cv;
  logic signed [47:0] cval;
  logic signed [47:0] cos_q [MAX_TERMS];
  logic signed [47:0] cphi, ceta;
  logic signed [63:0] base_v, epsc, sum, pert, tsum;
  logic signed [63:0] ma, mb;
  logic [31:0] ma_mag;
  logic [63:0] mb_mag;
  logic [5:0] msh;
  logic [63:0] mp_lo, mp_hi;
  logic [127:0] mp;
  logic signed [63:0] mres;
  logic [1:0] mstage;
  logic signed [63:0] m_result;
  logic mneg;
  logic [1:0] phase_sel;
  logic ovf;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      base_amp <= '0; pert_scale <= '0; wave <= 8'd1; terms_reg <= '0;
    end else if (cfg_we) begin
      case ({1'b0, cfg_index})
        REG_BASE:  base_amp   <= cfg_data;
        REG_PERT:  pert_scale <= cfg_data;
        REG_WAVE:  wave       <= cfg_data[7:0];
        REG_TERMS: terms_reg  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end
  assign nterms = (terms_reg > 6'(MAX_TERMS)) ? (IDX_W+1)'(MAX_TERMS)
                                                : (IDX_W+1)'(terms_reg);

  wire in_fire  = in_ch.valid && in_ch.ready;
  wire out_fire = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (state == ST_IDLE) && !out_ch.valid;

  // coefficient memory
  always_ff @(posedge clk) begin
    if (in_fire && in_ch.cmd == CMD_LOAD && 32'(in_ch.coef_index) < MAX_TERMS)
      coef_mem[in_ch.coef_index[IDX_W-1:0]] <= in_ch.coef_value;
    coef_rd <= coef_mem[mac_cnt[IDX_W-1:0]];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_fire && in_ch.cmd == CMD_EVAL) state_next = ST_PHASE;
      ST_PHASE:  state_next = ST_PHASE2;
      ST_PHASE2: state_next = (phase_sel == 2'd1) ? ST_ANGLE : ST_PHASE;
      ST_ANGLE:  state_next = ST_COS;
      ST_COS:    if (rx_cnt == nterms + 2 && !issue_v) state_next = ST_SCALE;
      ST_SCALE:  if (mstage == 2'd3) state_next = ST_PROD;
      ST_PROD:   if (mstage == 2'd3) state_next = ST_TERM;
      ST_TERM:   if (mac_cnt == nterms && mstage == 2'd0) state_next = ST_FINAL;
      ST_FINAL:  if (mstage == 2'd3) state_next = ST_OUT;
      ST_OUT:    state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // phase of both angles, one 64x32 product split in two halves
  wire signed [31:0] cur = (phase_sel == 2'd0) ? lat_q : lon_q;
  always_comb begin
    fang = 40'((((64'(mag_q[31:0]) * 64'(INV2PI[31:0])) >> 32)
                + 64'(mag_q[31:0]) * 64'(INV2PI[63:32])) >> 20);
    if (cur[31]) fang = -fang;
  end
  always_ff @(posedge clk) begin
    if (in_fire) begin
      lat_q <= in_ch.latitude; lon_q <= in_ch.longitude; phase_sel <= 2'd0;
    end
    if (state == ST_PHASE) begin
      mag_q  <= 64'(cur[31] ? -33'(cur) : 33'(cur));
    end
    if (state == ST_PHASE2) begin
      if (phase_sel == 2'd0) fphi <= fang; else feta <= fang;
      phase_sel <= phase_sel + 2'd1;
    end
  end

  // issue angles to the CORDIC row: phi, kappa*eta, then odd multiples
  always_comb begin
    issue_go = (state == ST_COS) && (issue_cnt < nterms + 2);
    case (issue_cnt)
      '0: odd_ang = fphi;
      (IDX_W+1)'(1): odd_ang = keta;
      default: odd_ang = step_ang;
    endcase
  end
  always_ff @(posedge clk) begin
    if (state == ST_ANGLE) begin
      issue_cnt <= '0; rx_cnt <= '0; step_ang <= fphi;
      keta <= 40'(64'(wave) * 64'(feta));
    end else begin
      if (issue_go) begin
        issue_cnt <= issue_cnt + 1'b1;
        if (issue_cnt >= (IDX_W+1)'(2)) step_ang <= step_ang + {fphi[38:0], 1'b0};
      end
      if (cv) rx_cnt <= rx_cnt + 1'b1;
    end
  end
  assign issue_v = 1'b0;

  ocsv_cordic u_cordic (.clk(clk), .rst(rst), .in_valid(issue_go),
                        .phase(odd_ang), .out_valid(cv), .cos_out(cval));

  always_ff @(posedge clk) begin
    if (cv) begin
      if (rx_cnt == '0) cphi <= cval;
      else if (rx_cnt == (IDX_W+1)'(1)) ceta <= cval;
      else cos_q[rx_cnt[IDX_W-1:0] - IDX_W'(2)] <= cval;
    end
  end

  // shared sign-magnitude multiplier; stage 0
  // waits for the coefficient read, stage 1 forms two 32x32 partial products
  always_comb begin
    ma = '0; mb = '0; msh = 6'd30;
    case (state)
      ST_SCALE: begin ma = 64'(base_amp); mb = 64'(cphi); end
      ST_PROD:  begin ma = 64'(pert_scale); mb = 64'(ceta); end
      ST_TERM:  begin ma = 64'(coef_rd); mb = 64'(cos_q[mac_cnt[IDX_W-1:0]]);
                      msh = 6'd16; end
      ST_FINAL: begin ma = epsc; mb = sum; end
      default: ;
    endcase
  end
  // first operand never exceeds 2^31 in magnitude
  always_comb begin
    ma_mag = 32'(ma < 0 ? -ma : ma);
    mb_mag = 64'(mb < 0 ? -mb : mb);
    mp = (128'(mp_hi) << 32) + 128'(mp_lo);
  end
  always_ff @(posedge clk) begin
    if (state == ST_ANGLE || state == ST_OUT || state == ST_IDLE) mstage <= '0;
    else if (state != ST_COS) begin
      if (state == ST_TERM && mac_cnt == nterms) mstage <= '0;
      else mstage <= mstage + 2'd1;
    end
    if (mstage == 2'd1) begin
      mneg  <= (ma < 0) != (mb < 0);
      mp_lo <= 64'(ma_mag) * 64'(mb_mag[31:0]);
      mp_hi <= 64'(ma_mag) * 64'(mb_mag[63:32]);
    end
    if (mstage == 2'd2) begin
      m_result <= ((mp >> msh) > (128'd1 << 62)) ?
                  (mneg ? -(64'sd1 <<< 62) : (64'sd1 <<< 62)) :
                  (mneg ? -$signed(64'(mp >> msh)) : $signed(64'(mp >> msh)));
    end
  end
  assign mres = m_result;

  // accumulate
  always_ff @(posedge clk) begin
    if (state == ST_ANGLE) begin sum <= '0; mac_cnt <= '0; end
    if (mstage == 2'd3) begin
      case (state)
        ST_SCALE: base_v <= mres;
        ST_PROD:  epsc <= mres;
        ST_TERM:  begin sum <= sum + mres; mac_cnt <= mac_cnt + 1'b1; end
        ST_FINAL: pert <= mres;
        default: ;
      endcase
    end
  end

  // saturate and hold result
  assign tsum = base_v + pert;
  assign ovf  = (tsum > 64'sd2147483647) || (tsum < -64'sd2147483648);
  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (state == ST_OUT) out_ch.valid <= 1'b1;
    else if (out_fire) out_ch.valid <= 1'b0;
    if (state == ST_OUT) begin
      out_ch.saturated <= ovf;
      out_ch.velocity <= (tsum > 64'sd2147483647) ? 32'sh7FFFFFFF :
                         (tsum < -64'sd2147483648) ? 32'sh80000000 : 32'(tsum);
    end
  end
endmodule

// File: hdl/ocsv_checker.sv
// Port-level checks for odd_cosine_series_velocity, bound to the top level.
// The bind depends on odd_cosine_series_velocity.
`timescale 1ns / 1ps
module ocsv_checker (
  input logic clk,
  input logic rst,
  input logic in_valid, in_ready, in_cmd,
  input logic out_valid, out_ready,
  input logic [31:0] velocity,
  input logic saturated
);
  // a held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(velocity) && $stable(saturated))
    else $error("result changed while stalled");
  // no new item while a result waits
  a_block: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken with result pending");
  // a load never gives a result next cycle
  a_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_cmd |=> !out_valid)
    else $error("load produced a result");
  // saturation means a rail value
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> velocity == 32'h7FFFFFFF || velocity == 32'h80000000)
    else $error("saturated flag without rail value");
endmodule

bind odd_cosine_series_velocity ocsv_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .in_cmd(in_ch.cmd), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .velocity(out_ch.velocity), .saturated(out_ch.saturated));
